FILE: design/log_linear_curve_interpolator_defines.svh
// Assertion macros for the curve interpolator RTL.
// Included by name from the modules that carry assertions; needs nothing else.
`ifndef LOG_LINEAR_CURVE_INTERPOLATOR_DEFINES_SVH
`define LOG_LINEAR_CURVE_INTERPOLATOR_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define LLI_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define LLI_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: design/lli_pkg.sv
// Shared types, constants and the Taylor reciprocal table of the curve interpolator.
// Depends on nothing; used by lli_datapath, lli_ctrl and the top level.
`default_nettype none

package lli_pkg;

    localparam int MAX_NODES_DEF     = 32;
    localparam int LOG_FRAC_BITS_DEF = 24;
    localparam int RATE_FRAC_BITS    = 24;
    localparam int TAYLOR_TERMS      = 14;

    localparam logic [31:0] LN2_Q32       = 32'hB172_17F8;
    localparam logic [8:0]  DAYS_PER_YEAR = 9'd365;

    // floor(2^48 / LN2_Q32): reciprocal used for the range reduction by ln2.
    localparam logic [16:0] LN2_RECIP = 17'd94548;

    // Shared divider: numerator holds |df1 - df2| * 365 (41 bits) shifted up by
    // one more bit than the rate fraction; denominator holds df2 * days.
    localparam int DIV_NW = 41 + RATE_FRAC_BITS + 1;
    localparam int DIV_DW = 48;

    typedef enum logic [1:0] {
        REQ_LOAD = 2'd0,
        REQ_DF   = 2'd1,
        REQ_FWD  = 2'd2,
        REQ_NONE = 2'd3
    } req_t;

    typedef enum logic [4:0] {
        S_IDLE,
        S_RD_LAST,
        S_RD_FIRST,
        S_SCAN0,
        S_SCAN,
        S_IMUL,
        S_IDIV,
        S_IWAIT,
        S_IEND,
        S_XDIV,
        S_XWAIT,
        S_XEND,
        S_TMUL1,
        S_TMUL2,
        S_TCORR,
        S_EEND,
        S_FMUL,
        S_FDIV,
        S_FWAIT,
        S_FEND,
        S_DONE
    } state_t;

    typedef enum logic [4:0] {
        OP_IDLE,
        OP_ACCEPT,
        OP_RD_LAST,
        OP_RD_FIRST,
        OP_SCAN0,
        OP_SCAN,
        OP_IMUL,
        OP_IDIV_START,
        OP_IDIV_END,
        OP_XDIV_START,
        OP_XREM,
        OP_XDIV_END,
        OP_TMUL1,
        OP_TMUL2,
        OP_TCORR,
        OP_EXP_END,
        OP_FMUL,
        OP_FDIV_START,
        OP_FDIV_END,
        OP_WAIT
    } op_t;

    typedef struct packed {
        logic le_first;   // date at or before the first node
        logic ge_last;    // date at or after the last node in use
        logic in_iv;      // date inside the interval now being scanned
        logic at_last;    // scan has reached the last node in use
        logic div_done;   // divider has finished
        logic t_last;     // final Taylor term is being added
        logic is_fwd;     // current word is a forward query
        logic pass_b;     // working on the end date
        logic bad_dates;  // end date not after start date
    } dp_status_t;

    // floor(2^33 / i) for the Taylor term divisors.
    function automatic logic [33:0] taylor_recip(input logic [3:0] i);
        logic [33:0] r;
        begin
            case (i)
                4'd1:    r = 34'd8589934592;
                4'd2:    r = 34'd4294967296;
                4'd3:    r = 34'd2863311530;
                4'd4:    r = 34'd2147483648;
                4'd5:    r = 34'd1717986918;
                4'd6:    r = 34'd1431655765;
                4'd7:    r = 34'd1227133513;
                4'd8:    r = 34'd1073741824;
                4'd9:    r = 34'd954437176;
                4'd10:   r = 34'd858993459;
                4'd11:   r = 34'd780903144;
                4'd12:   r = 34'd715827882;
                4'd13:   r = 34'd660764199;
                4'd14:   r = 34'd613566756;
                default: r = 34'd0;
            endcase
            return r;
        end
    endfunction

endpackage

`default_nettype wire

FILE: design/lli_ram.sv
// Generic single-write, single-read RAM with a registered read port.
// Depends on nothing.
`default_nettype none

module lli_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 32
) (
    input  wire logic                     clk,
    input  wire logic                     wr_en,
    input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
    input  wire logic [WIDTH-1:0]         wr_data,
    input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic      [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem_reg[wr_addr] <= wr_data;
        end
        rd_data_reg <= mem_reg[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule

`default_nettype wire

FILE: design/lli_div.sv
// Restoring unsigned divider, one quotient bit per cycle, shared by the interpolation
// and forward rate divisions. Depends on nothing.
`default_nettype none

module lli_div #(
    parameter int NW = 66,
    parameter int DW = 48
) (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          start,
    input  wire logic [NW-1:0] num,
    input  wire logic [DW-1:0] den,
    output logic               done,
    output logic      [NW-1:0] quo
);

    localparam int CW = $clog2(NW + 1);

    logic [NW-1:0] nq_reg, nq_next;
    logic [DW-1:0] rem_reg, rem_next;
    logic [DW-1:0] den_reg, den_next;
    logic [CW-1:0] cnt_reg, cnt_next;
    logic          done_reg, done_next;
    logic [DW:0]   rem_sh;
    logic          qbit;

    always_comb
    begin
        rem_sh    = {rem_reg, nq_reg[NW-1]};
        qbit      = rem_sh >= {1'b0, den_reg};
        nq_next   = nq_reg;
        rem_next  = rem_reg;
        den_next  = den_reg;
        cnt_next  = cnt_reg;
        done_next = 1'b0;
        if (start)
        begin
            nq_next  = num;
            rem_next = '0;
            den_next = den;
            cnt_next = CW'(NW);
        end
        else if (cnt_reg != '0)
        begin
            nq_next   = {nq_reg[NW-2:0], qbit};
            rem_next  = qbit ? DW'(rem_sh - {1'b0, den_reg}) : rem_sh[DW-1:0];
            cnt_next  = cnt_reg - CW'(1);
            done_next = cnt_reg == CW'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            done_reg <= 1'b0;
        end
        else
        begin
            cnt_reg  <= cnt_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        nq_reg  <= nq_next;
        rem_reg <= rem_next;
        den_reg <= den_next;
    end

    assign done = done_reg;
    assign quo  = nq_reg;

endmodule

`default_nettype wire

FILE: design/lli_datapath.sv
// Datapath: node tables, node search, interpolation, exponential and forward rate.
// Depends on lli_pkg, lli_ram and lli_div; driven by lli_ctrl through an op code.
`default_nettype none

module lli_datapath #(
    parameter int MAX_NODES     = lli_pkg::MAX_NODES_DEF,
    parameter int LOG_FRAC_BITS = lli_pkg::LOG_FRAC_BITS_DEF
) (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire lli_pkg::op_t       op,
    output lli_pkg::dp_status_t     st,
    input  wire logic               cfg_valid,
    output logic                    cfg_ready,
    input  wire logic [5:0]         cfg_data,
    input  wire logic [1:0]         req_type,
    input  wire logic [4:0]         node_index,
    input  wire logic signed [31:0] node_log_df,
    input  wire logic [15:0]        date_a,
    input  wire logic [15:0]        date_b,
    output logic [31:0]             discount_factor,
    output logic signed [31:0]      fwd_rate,
    output logic                    status
);

    localparam int AW     = $clog2(MAX_NODES);
    localparam int XSHIFT = 32 - LOG_FRAC_BITS;
    localparam int NW     = lli_pkg::DIV_NW;
    localparam int DW     = lli_pkg::DIV_DW;

    // Registers
    logic [5:0]   nc_reg, nc_next;
    logic [1:0]   req_reg, req_next;
    logic [15:0]  da_reg, da_next, db_reg, db_next;
    logic         pass_reg, pass_next;
    logic [AW-1:0] rd_idx_reg, rd_idx_next;
    logic [15:0]  last_day_reg, last_day_next, prev_day_reg, prev_day_next;
    logic [15:0]  cur_day_reg, cur_day_next;
    logic [31:0]  last_log_reg, last_log_next, prev_log_reg, prev_log_next;
    logic [31:0]  cur_log_reg, cur_log_next;
    logic [31:0]  x_reg, x_next;
    logic [47:0]  prod_reg, prod_next;
    logic [15:0]  span_reg, span_next;
    logic         neg_reg, neg_next;
    logic [16:0]  xq_reg, xq_next;
    logic [32:0]  xr_reg, xr_next;
    logic signed [19:0] k_reg, k_next;
    logic [31:0]  r_reg, r_next;
    logic [32:0]  term_reg, term_next, tn_reg, tn_next, est_reg, est_next;
    logic [34:0]  sum_reg, sum_next;
    logic [3:0]   ti_reg, ti_next;
    logic [31:0]  df1_reg, df1_next, df2_reg, df2_next;
    logic [40:0]  fm_reg, fm_next;
    logic [47:0]  fden_reg, fden_next;
    logic         fneg_reg, fneg_next;
    logic [31:0]  df_out_reg, df_out_next, rate_reg, rate_next;
    logic         status_reg, status_next;

    // Memory ports
    logic          ram_we;
    logic [AW-1:0] ram_waddr, ram_raddr;
    logic [15:0]   day_q;
    logic [31:0]   log_q;

    // Divider ports
    logic          div_start, div_done;
    logic [NW-1:0] div_num, div_quo;
    logic [DW-1:0] div_den;

    // Working signals
    logic [AW-1:0] last_idx;
    logic [15:0]   t_cur, dt, span, days;
    logic          slot_ok;
    logic [32:0]   ldiff;
    logic [31:0]   lmag;
    logic [33:0]   l0e, xi;
    logic [47:0]   xs_u, xmag;
    logic [64:0]   xprod;
    logic [47:0]   xqm, xsub;
    logic          xfix;
    logic [32:0]   xrc;
    logic [19:0]   qk;
    logic [31:0]   xrem;
    logic [64:0]   tmul;
    logic [66:0]   emul;
    logic [36:0]   est_i, chk;
    logic [32:0]   term_new;
    logic signed [19:0] es;
    logic [5:0]    sh;
    logic [40:0]   ext, shifted;
    logic [31:0]   df, dd, qr32;
    logic [32:0]   qsum;

    lli_ram #(.WIDTH(16), .DEPTH(MAX_NODES)) u_day_ram (
        .clk     (clk),
        .wr_en   (ram_we),
        .wr_addr (ram_waddr),
        .wr_data (date_a),
        .rd_addr (ram_raddr),
        .rd_data (day_q)
    );

    lli_ram #(.WIDTH(32), .DEPTH(MAX_NODES)) u_log_ram (
        .clk     (clk),
        .wr_en   (ram_we),
        .wr_addr (ram_waddr),
        .wr_data (node_log_df),
        .rd_addr (ram_raddr),
        .rd_data (log_q)
    );

    lli_div #(.NW(NW), .DW(DW)) u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .start (div_start),
        .num   (div_num),
        .den   (div_den),
        .done  (div_done),
        .quo   (div_quo)
    );

    // Node count register: zero acts as one, anything above the table size as the size.
    always_comb
    begin
        if (nc_reg == '0)
        begin
            last_idx = '0;
        end
        else if (int'(nc_reg) > MAX_NODES)
        begin
            last_idx = AW'(MAX_NODES - 1);
        end
        else
        begin
            last_idx = AW'(int'(nc_reg) - 1);
        end
    end

    assign cfg_ready = 1'b1;
    assign nc_next   = (cfg_valid && cfg_ready) ? cfg_data : nc_reg;

    assign t_cur   = pass_reg ? db_reg : da_reg;
    assign slot_ok = int'(node_index) < MAX_NODES;
    assign ram_we  = (op == lli_pkg::OP_ACCEPT) && (req_type == lli_pkg::REQ_LOAD) && slot_ok;
    assign ram_waddr = AW'(node_index);

    always_comb
    begin
        case (op)
            lli_pkg::OP_RD_LAST: ram_raddr = last_idx;
            lli_pkg::OP_SCAN0:   ram_raddr = AW'(1);
            lli_pkg::OP_SCAN:    ram_raddr = rd_idx_reg + AW'(1);
            default:             ram_raddr = '0;
        endcase
    end

    // Status towards the controller
    always_comb
    begin
        st.le_first  = t_cur <= day_q;
        st.ge_last   = t_cur >= last_day_reg;
        st.in_iv     = (prev_day_reg <= t_cur) && (t_cur < day_q);
        st.at_last   = rd_idx_reg == last_idx;
        st.div_done  = div_done;
        st.t_last    = ti_reg == 4'(lli_pkg::TAYLOR_TERMS);
        st.is_fwd    = req_reg == lli_pkg::REQ_FWD;
        st.pass_b    = pass_reg;
        st.bad_dates = db_reg <= da_reg;
    end

    // Arithmetic shared by the op cases
    always_comb
    begin
        ldiff = {cur_log_reg[31], cur_log_reg} - {prev_log_reg[31], prev_log_reg};
        lmag  = ldiff[32] ? 32'(33'd0 - ldiff) : ldiff[31:0];
        dt    = t_cur - prev_day_reg;
        span  = cur_day_reg - prev_day_reg;
        l0e   = {{2{prev_log_reg[31]}}, prev_log_reg};
        xi    = neg_reg ? l0e - {1'b0, div_quo[32:0]} : l0e + {1'b0, div_quo[32:0]};

        // Range reduction by ln2: the reciprocal estimate is at most one below the
        // true quotient, so one compare and subtract finishes it.
        xs_u  = {{16{x_reg[31]}}, x_reg} << XSHIFT;
        xmag  = x_reg[31] ? 48'd0 - xs_u : xs_u;
        xprod = {17'd0, xmag} * {48'd0, lli_pkg::LN2_RECIP};
        xqm   = {31'd0, xq_reg} * {16'd0, lli_pkg::LN2_Q32};
        xsub  = xmag - xqm;
        xfix  = xr_reg >= {1'b0, lli_pkg::LN2_Q32};
        xrc   = xfix ? xr_reg - {1'b0, lli_pkg::LN2_Q32} : xr_reg;
        qk    = 20'(xq_reg) + 20'(xfix);
        xrem  = xrc[31:0];

        tmul  = {32'd0, term_reg} * {33'd0, r_reg};
        emul  = {34'd0, tn_reg} * {33'd0, lli_pkg::taylor_recip(ti_reg)};
        est_i = {4'd0, est_reg} * {33'd0, ti_reg};
        chk   = {4'd0, tn_reg} - est_i;
        term_new = est_reg + 33'(chk >= {33'd0, ti_reg});

        // Scale the Taylor sum by 2^k and round into Q2.30.
        es      = 20'sd2 - k_reg;
        sh      = es[5:0];
        ext     = 41'(sum_reg) + (41'd1 << (sh - 6'd1));
        shifted = ext >> sh;
        if (k_reg >= 20'sd2)
        begin
            df = 32'hFFFF_FFFF;
        end
        else if (es >= 20'sd40)
        begin
            df = 32'd0;
        end
        else if (shifted[40:32] != '0)
        begin
            df = 32'hFFFF_FFFF;
        end
        else
        begin
            df = shifted[31:0];
        end

        dd    = (df1_reg < df2_reg) ? df2_reg - df1_reg : df1_reg - df2_reg;
        days  = db_reg - da_reg;
        qsum  = {1'b0, div_quo[31:0]} + 33'd1;
        qr32  = qsum[32:1];
    end

    // Divider operands
    always_comb
    begin
        div_start = 1'b0;
        div_num   = '0;
        div_den   = '0;
        case (op)
            lli_pkg::OP_IDIV_START:
            begin
                div_start = 1'b1;
                div_num   = NW'(prod_reg) + NW'(span_reg >> 1);
                div_den   = DW'(span_reg);
            end
            lli_pkg::OP_FDIV_START:
            begin
                div_start = 1'b1;
                div_num   = NW'(fm_reg) << (lli_pkg::RATE_FRAC_BITS + 1);
                div_den   = fden_reg;
            end
            default:
            begin
                div_start = 1'b0;
            end
        endcase
    end

    // Next-state of the datapath registers
    always_comb
    begin
        req_next      = req_reg;
        da_next       = da_reg;
        db_next       = db_reg;
        pass_next     = pass_reg;
        rd_idx_next   = rd_idx_reg;
        last_day_next = last_day_reg;
        last_log_next = last_log_reg;
        prev_day_next = prev_day_reg;
        prev_log_next = prev_log_reg;
        cur_day_next  = cur_day_reg;
        cur_log_next  = cur_log_reg;
        x_next        = x_reg;
        prod_next     = prod_reg;
        span_next     = span_reg;
        neg_next      = neg_reg;
        xq_next       = xq_reg;
        xr_next       = xr_reg;
        k_next        = k_reg;
        r_next        = r_reg;
        term_next     = term_reg;
        tn_next       = tn_reg;
        est_next      = est_reg;
        sum_next      = sum_reg;
        ti_next       = ti_reg;
        df1_next      = df1_reg;
        df2_next      = df2_reg;
        fm_next       = fm_reg;
        fden_next     = fden_reg;
        fneg_next     = fneg_reg;
        df_out_next   = df_out_reg;
        rate_next     = rate_reg;
        status_next   = status_reg;

        case (op)
            lli_pkg::OP_ACCEPT:
            begin
                req_next    = req_type;
                da_next     = date_a;
                db_next     = date_b;
                pass_next   = 1'b0;
                df_out_next = '0;
                rate_next   = '0;
                status_next = 1'b0;
            end
            lli_pkg::OP_RD_FIRST:
            begin
                last_day_next = day_q;
                last_log_next = log_q;
            end
            lli_pkg::OP_SCAN0:
            begin
                if (st.le_first)
                begin
                    x_next = log_q;
                end
                else if (st.ge_last)
                begin
                    x_next = last_log_reg;
                end
                prev_day_next = day_q;
                prev_log_next = log_q;
                rd_idx_next   = AW'(1);
            end
            lli_pkg::OP_SCAN:
            begin
                if (st.in_iv)
                begin
                    cur_day_next = day_q;
                    cur_log_next = log_q;
                end
                else if (st.at_last)
                begin
                    x_next = last_log_reg;
                end
                else
                begin
                    prev_day_next = day_q;
                    prev_log_next = log_q;
                    rd_idx_next   = rd_idx_reg + AW'(1);
                end
            end
            lli_pkg::OP_IMUL:
            begin
                prod_next = {16'd0, lmag} * {32'd0, dt};
                span_next = span;
                neg_next  = ldiff[32];
            end
            lli_pkg::OP_IDIV_END:
            begin
                x_next = xi[31:0];
            end
            lli_pkg::OP_XDIV_START:
            begin
                xq_next = xprod[64:48];
            end
            lli_pkg::OP_XREM:
            begin
                xr_next = xsub[32:0];
            end
            lli_pkg::OP_XDIV_END:
            begin
                if (x_reg[31])
                begin
                    if (xrem != '0)
                    begin
                        k_next = signed'(~qk);
                        r_next = lli_pkg::LN2_Q32 - xrem;
                    end
                    else
                    begin
                        k_next = signed'(20'd0 - qk);
                        r_next = '0;
                    end
                end
                else
                begin
                    k_next = signed'(qk);
                    r_next = xrem;
                end
                term_next = 33'h1_0000_0000;
                sum_next  = 35'h1_0000_0000;
                ti_next   = 4'd1;
            end
            lli_pkg::OP_TMUL1:
            begin
                tn_next = tmul[64:32];
            end
            lli_pkg::OP_TMUL2:
            begin
                est_next = emul[65:33];
            end
            lli_pkg::OP_TCORR:
            begin
                term_next = term_new;
                sum_next  = sum_reg + 35'(term_new);
                ti_next   = ti_reg + 4'd1;
            end
            lli_pkg::OP_EXP_END:
            begin
                pass_next = 1'b1;
                if (!pass_reg)
                begin
                    df1_next    = df;
                    df_out_next = df;
                    if (st.is_fwd && st.bad_dates)
                    begin
                        status_next = 1'b1;
                    end
                end
                else
                begin
                    df2_next = df;
                end
            end
            lli_pkg::OP_FMUL:
            begin
                fneg_next = df1_reg < df2_reg;
                fm_next   = {9'd0, dd} * {32'd0, lli_pkg::DAYS_PER_YEAR};
                fden_next = {16'd0, df2_reg} * {32'd0, days};
            end
            lli_pkg::OP_FDIV_END:
            begin
                if (df2_reg == '0)
                begin
                    rate_next = (df1_reg == '0) ? 32'd0 : 32'h7FFF_FFFF;
                end
                else if (div_quo[NW-1:32] != '0)
                begin
                    rate_next = fneg_reg ? 32'h8000_0000 : 32'h7FFF_FFFF;
                end
                else if (!fneg_reg)
                begin
                    rate_next = (qr32 > 32'h7FFF_FFFF) ? 32'h7FFF_FFFF : qr32;
                end
                else
                begin
                    rate_next = 32'd0 - qr32;
                end
            end
            default:
            begin
                pass_next = pass_reg;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            nc_reg <= 6'd1;
        end
        else
        begin
            nc_reg <= nc_next;
        end
    end

    always_ff @(posedge clk)
    begin
        req_reg      <= req_next;
        da_reg       <= da_next;
        db_reg       <= db_next;
        pass_reg     <= pass_next;
        rd_idx_reg   <= rd_idx_next;
        last_day_reg <= last_day_next;
        last_log_reg <= last_log_next;
        prev_day_reg <= prev_day_next;
        prev_log_reg <= prev_log_next;
        cur_day_reg  <= cur_day_next;
        cur_log_reg  <= cur_log_next;
        x_reg        <= x_next;
        prod_reg     <= prod_next;
        span_reg     <= span_next;
        neg_reg      <= neg_next;
        xq_reg       <= xq_next;
        xr_reg       <= xr_next;
        k_reg        <= k_next;
        r_reg        <= r_next;
        term_reg     <= term_next;
        tn_reg       <= tn_next;
        est_reg      <= est_next;
        sum_reg      <= sum_next;
        ti_reg       <= ti_next;
        df1_reg      <= df1_next;
        df2_reg      <= df2_next;
        fm_reg       <= fm_next;
        fden_reg     <= fden_next;
        fneg_reg     <= fneg_next;
        df_out_reg   <= df_out_next;
        rate_reg     <= rate_next;
        status_reg   <= status_next;
    end

    assign discount_factor = df_out_reg;
    assign fwd_rate        = signed'(rate_reg);
    assign status          = status_reg;

endmodule

`default_nettype wire

FILE: design/lli_ctrl.sv
// Sequencer of the curve interpolator: one state per datapath operation.
// Depends on lli_pkg and the assertion macros header.
`default_nettype none

`include "log_linear_curve_interpolator_defines.svh"

module lli_ctrl (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                start,
    input  wire logic [1:0]          req_type,
    input  wire lli_pkg::dp_status_t st,
    output lli_pkg::op_t             op,
    output logic                     busy,
    output logic                     done
);

    lli_pkg::state_t state_reg, state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= lli_pkg::S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        op         = lli_pkg::OP_IDLE;
        done       = 1'b0;
        case (state_reg)
            lli_pkg::S_IDLE:
            begin
                if (start)
                begin
                    op = lli_pkg::OP_ACCEPT;
                    if (req_type == lli_pkg::REQ_DF || req_type == lli_pkg::REQ_FWD)
                    begin
                        state_next = lli_pkg::S_RD_LAST;
                    end
                    else
                    begin
                        state_next = lli_pkg::S_DONE;
                    end
                end
            end
            lli_pkg::S_RD_LAST:
            begin
                op         = lli_pkg::OP_RD_LAST;
                state_next = lli_pkg::S_RD_FIRST;
            end
            lli_pkg::S_RD_FIRST:
            begin
                op         = lli_pkg::OP_RD_FIRST;
                state_next = lli_pkg::S_SCAN0;
            end
            lli_pkg::S_SCAN0:
            begin
                op = lli_pkg::OP_SCAN0;
                if (st.le_first || st.ge_last)
                begin
                    state_next = lli_pkg::S_XDIV;
                end
                else
                begin
                    state_next = lli_pkg::S_SCAN;
                end
            end
            lli_pkg::S_SCAN:
            begin
                op = lli_pkg::OP_SCAN;
                if (st.in_iv)
                begin
                    state_next = lli_pkg::S_IMUL;
                end
                else if (st.at_last)
                begin
                    state_next = lli_pkg::S_XDIV;
                end
            end
            lli_pkg::S_IMUL:
            begin
                op         = lli_pkg::OP_IMUL;
                state_next = lli_pkg::S_IDIV;
            end
            lli_pkg::S_IDIV:
            begin
                op         = lli_pkg::OP_IDIV_START;
                state_next = lli_pkg::S_IWAIT;
            end
            lli_pkg::S_IWAIT:
            begin
                op = lli_pkg::OP_WAIT;
                if (st.div_done)
                begin
                    state_next = lli_pkg::S_IEND;
                end
            end
            lli_pkg::S_IEND:
            begin
                op         = lli_pkg::OP_IDIV_END;
                state_next = lli_pkg::S_XDIV;
            end
            lli_pkg::S_XDIV:
            begin
                op         = lli_pkg::OP_XDIV_START;
                state_next = lli_pkg::S_XWAIT;
            end
            lli_pkg::S_XWAIT:
            begin
                op         = lli_pkg::OP_XREM;
                state_next = lli_pkg::S_XEND;
            end
            lli_pkg::S_XEND:
            begin
                op         = lli_pkg::OP_XDIV_END;
                state_next = lli_pkg::S_TMUL1;
            end
            lli_pkg::S_TMUL1:
            begin
                op         = lli_pkg::OP_TMUL1;
                state_next = lli_pkg::S_TMUL2;
            end
            lli_pkg::S_TMUL2:
            begin
                op         = lli_pkg::OP_TMUL2;
                state_next = lli_pkg::S_TCORR;
            end
            lli_pkg::S_TCORR:
            begin
                op = lli_pkg::OP_TCORR;
                if (st.t_last)
                begin
                    state_next = lli_pkg::S_EEND;
                end
                else
                begin
                    state_next = lli_pkg::S_TMUL1;
                end
            end
            lli_pkg::S_EEND:
            begin
                op = lli_pkg::OP_EXP_END;
                if (st.is_fwd && !st.pass_b && !st.bad_dates)
                begin
                    state_next = lli_pkg::S_RD_LAST;
                end
                else if (st.is_fwd && st.pass_b)
                begin
                    state_next = lli_pkg::S_FMUL;
                end
                else
                begin
                    state_next = lli_pkg::S_DONE;
                end
            end
            lli_pkg::S_FMUL:
            begin
                op         = lli_pkg::OP_FMUL;
                state_next = lli_pkg::S_FDIV;
            end
            lli_pkg::S_FDIV:
            begin
                op         = lli_pkg::OP_FDIV_START;
                state_next = lli_pkg::S_FWAIT;
            end
            lli_pkg::S_FWAIT:
            begin
                op = lli_pkg::OP_WAIT;
                if (st.div_done)
                begin
                    state_next = lli_pkg::S_FEND;
                end
            end
            lli_pkg::S_FEND:
            begin
                op         = lli_pkg::OP_FDIV_END;
                state_next = lli_pkg::S_DONE;
            end
            lli_pkg::S_DONE:
            begin
                done       = 1'b1;
                state_next = lli_pkg::S_IDLE;
            end
            default:
            begin
                state_next = lli_pkg::S_IDLE;
            end
        endcase
    end

    assign busy = state_reg != lli_pkg::S_IDLE;

    `LLI_ASSERT_NEXT(a_load_one_cycle, clk, rst_n, start && !busy && req_type == lli_pkg::REQ_LOAD, done, "load word did not complete in the following cycle")
    `LLI_ASSERT_NEXT(a_query_not_immediate, clk, rst_n, start && !busy && (req_type == lli_pkg::REQ_DF || req_type == lli_pkg::REQ_FWD), busy && !done, "query word finished too early")
    `LLI_ASSERT_NEXT(a_done_then_idle, clk, rst_n, done, !busy && !done, "result strobe not followed by idle")
    `LLI_ASSERT_NOW(a_div_done_waiting, clk, rst_n, st.div_done, state_reg == lli_pkg::S_IWAIT || state_reg == lli_pkg::S_FWAIT, "divider finished outside a wait state")

endmodule

`default_nettype wire

FILE: design/log_linear_curve_interpolator.sv
// Top level of the log-linear discount curve interpolator.
// Depends on lli_pkg, lli_ctrl and lli_datapath (which holds lli_ram and lli_div).
//
//  Channel   Handshake               Payload
//  --------  ----------------------  -----------------------------------------------
//  request   start, busy             req_type, node_index, node_log_df, date_a, date_b
//  result    done (one-cycle strobe) discount_factor, fwd_rate, status
//  config    cfg_valid, cfg_ready    cfg_data (node count)
//
// A request word is taken when start is high and busy is low; one word is worked on at a time.
// A load word, or an unused request code, gives its all-zero result in the cycle after
// acceptance. A query works per date through the node scan (last node, first node, then each
// interval in turn), an interpolation step round the shared bit-serial divide when the date
// falls inside an interval, a range reduction by reciprocal multiplication, the Taylor series
// and a finishing step; a forward query does this for both dates and then a further rate step
// round the divide, but stops after the first date with status set if the end date is not
// after the start date.
// Reset is asynchronous and active low; it clears the sequencer and sets the node count to one.
// The node tables are undefined until loaded. Results cannot be stalled by the receiver.
`default_nettype none

module log_linear_curve_interpolator #(
    parameter int MAX_NODES     = lli_pkg::MAX_NODES_DEF,
    parameter int LOG_FRAC_BITS = lli_pkg::LOG_FRAC_BITS_DEF
) (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               start,
    output logic                    busy,
    input  wire logic [1:0]         req_type,
    input  wire logic [4:0]         node_index,
    input  wire logic signed [31:0] node_log_df,
    input  wire logic [15:0]        date_a,
    input  wire logic [15:0]        date_b,
    output logic                    done,
    output logic [31:0]             discount_factor,
    output logic signed [31:0]      fwd_rate,
    output logic                    status,
    input  wire logic               cfg_valid,
    output logic                    cfg_ready,
    input  wire logic [5:0]         cfg_data
);

    // The sequencer issues one operation per cycle; the datapath reports the flags that steer it.
    lli_pkg::op_t        op;
    lli_pkg::dp_status_t st;

    lli_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (start),
        .req_type (req_type),
        .st       (st),
        .op       (op),
        .busy     (busy),
        .done     (done)
    );

    lli_datapath #(
        .MAX_NODES     (MAX_NODES),
        .LOG_FRAC_BITS (LOG_FRAC_BITS)
    ) u_datapath (
        .clk             (clk),
        .rst_n           (rst_n),
        .op              (op),
        .st              (st),
        .cfg_valid       (cfg_valid),
        .cfg_ready       (cfg_ready),
        .cfg_data        (cfg_data),
        .req_type        (req_type),
        .node_index      (node_index),
        .node_log_df     (node_log_df),
        .date_a          (date_a),
        .date_b          (date_b),
        .discount_factor (discount_factor),
        .fwd_rate        (fwd_rate),
        .status          (status)
    );

endmodule

`default_nettype wire
